@@ rtl/core/fba_pkg.sv @@
// Shared constants, codes and structs for the file block allocator table.
// No dependencies; imported by the controller, datapath and top level.
package fba_pkg;

  localparam int NUM_BLOCKS      = 128;
  localparam int NUM_ENTRIES     = 16;
  localparam int MAX_FILE_BLOCKS = 8;

  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int ENT_W   = $clog2(NUM_ENTRIES);
  localparam int POS_W   = $clog2(MAX_FILE_BLOCKS);
  localparam int AVAIL_W = BLK_W + 1;

  localparam int CHUNK      = 8;
  localparam int CHUNK_W    = $clog2(CHUNK);
  localparam int NUM_CHUNKS = NUM_BLOCKS / CHUNK;
  localparam int CHK_W      = $clog2(NUM_CHUNKS);

  localparam int PTR_DEPTH = NUM_ENTRIES * MAX_FILE_BLOCKS;

  localparam int REQ_W  = 2;
  localparam int NAME_W = 64;
  localparam int CNT_W  = 4;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 8;

  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FILE_BLOCKS);

  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE      = 3'd4;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE  = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [NAME_W-1:0] file_name;
    logic [CNT_W-1:0]  block_count;
    logic [CNT_W-1:0]  block_index;
  } fba_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  block_number;
    logic [ENT_W-1:0]  entry_slot;
  } fba_rsp_t;

  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_HELD,
    SLOT_SCAN
  } fba_slot_sel_t;

  typedef struct packed {
    logic              load;
    logic              count;
    logic              take_slot;
    logic              alloc;
    logic              commit;
    logic              search;
    logic              lookup_rd;
    logic              free_rd;
    logic              invalidate;
    logic              respond;
    logic [STAT_W-1:0] status;
    logic              use_blk;
    fba_slot_sel_t     slot_sel;
  } fba_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             too_large;
    logic             count_last;
    logic             no_space;
    logic             table_full;
    logic             alloc_done;
    logic             match;
    logic             scan_last;
    logic             range_bad;
    logic             free_more;
    logic             free_pend;
  } fba_stat_t;

endpackage

@@ rtl/core/fba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/fba_ctl.sv @@
// Controller state machine: sequences count, allocate, search, free and lookup.
// Depends on fba_pkg; drives the datapath through fba_cmd_t.
module fba_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fba_pkg::fba_stat_t stat_i,
  output fba_pkg::fba_cmd_t  cmd_o
);
  import fba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_COUNT,
    S_CHECK,
    S_ALLOC,
    S_SEARCH,
    S_FREE,
    S_LOOKUP
  } state_t;

  state_t   state_r;
  state_t   state_nxt;
  fba_cmd_t cmd;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat_i.req_type == REQ_CREATE) begin
          if (stat_i.too_large) begin
            cmd.respond = 1'b1;
            cmd.status  = ST_TOO_LARGE;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_COUNT;
          end
        end else if (stat_i.req_type == REQ_DELETE || stat_i.req_type == REQ_LOOKUP) begin
          state_nxt = S_SEARCH;
        end else begin
          cmd.respond = 1'b1;
          cmd.status  = ST_NOT_FOUND;
          state_nxt   = S_IDLE;
        end
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        if (stat_i.count_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat_i.no_space) begin
          cmd.respond = 1'b1;
          cmd.status  = ST_NO_SPACE;
          state_nxt   = S_IDLE;
        end else if (stat_i.table_full) begin
          cmd.respond = 1'b1;
          cmd.status  = ST_TABLE_FULL;
          state_nxt   = S_IDLE;
        end else begin
          cmd.take_slot = 1'b1;
          state_nxt     = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat_i.alloc_done) begin
          cmd.commit   = 1'b1;
          cmd.respond  = 1'b1;
          cmd.status   = ST_OK;
          cmd.slot_sel = SLOT_HELD;
          state_nxt    = S_IDLE;
        end else begin
          cmd.alloc = 1'b1;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        priority if (stat_i.match) begin
          priority if (stat_i.req_type == REQ_DELETE) begin
            state_nxt = S_FREE;
          end else if (stat_i.range_bad) begin
            cmd.respond  = 1'b1;
            cmd.status   = ST_RANGE;
            cmd.slot_sel = SLOT_SCAN;
            state_nxt    = S_IDLE;
          end else begin
            cmd.lookup_rd = 1'b1;
            state_nxt     = S_LOOKUP;
          end
        end else if (stat_i.scan_last) begin
          cmd.respond = 1'b1;
          cmd.status  = ST_NOT_FOUND;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_FREE: begin
        priority if (stat_i.free_more) begin
          cmd.free_rd = 1'b1;
        end else if (!stat_i.free_pend) begin
          cmd.invalidate = 1'b1;
          cmd.respond    = 1'b1;
          cmd.status     = ST_OK;
          cmd.slot_sel   = SLOT_HELD;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_FREE;
        end
      end
      S_LOOKUP: begin
        cmd.respond  = 1'b1;
        cmd.status   = ST_OK;
        cmd.use_blk  = 1'b1;
        cmd.slot_sel = SLOT_HELD;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign cmd_o = cmd;

`ifndef SYNTH
  a_respond_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> state_r == S_IDLE)
    else $error("controller did not return to idle after a result");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_DISPATCH)
    else $error("accepted item not dispatched");

  a_free_before_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.invalidate |-> !stat_i.free_more && !stat_i.free_pend)
    else $error("entry released before all blocks were freed");
`endif

endmodule

@@ rtl/core/fba_dp.sv @@
// Datapath: block map, entry table, pointer RAM, scan counters and result register.
// Depends on fba_pkg and fba_ram; commanded by fba_ctl.
module fba_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fba_pkg::fba_req_t         in_req,
  input  logic                      cfg_we,
  input  logic [fba_pkg::CFG_W-1:0] cfg_data,
  input  fba_pkg::fba_cmd_t         cmd_i,
  output fba_pkg::fba_stat_t        stat_o,
  output logic                      out_strobe,
  output fba_pkg::fba_rsp_t         out_rsp
);
  import fba_pkg::*;

  logic [CFG_W-1:0]       reserved_r;
  logic [NUM_BLOCKS-1:0]  map_r;
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [NAME_W-1:0]      name_r [NUM_ENTRIES];
  logic [CNT_W-1:0]       len_r  [NUM_ENTRIES];

  fba_req_t               req_r;
  logic [CHK_W-1:0]       chunk_r;
  logic [AVAIL_W-1:0]     avail_r;
  logic [ENT_W-1:0]       ent_r;
  logic [ENT_W-1:0]       slot_r;
  logic [CNT_W-1:0]       pos_r;
  logic [CNT_W-1:0]       flen_r;
  logic                   free_pend_r;
  logic                   out_strobe_r;
  fba_rsp_t               out_rsp_r;

  logic [CHUNK-1:0]       chunk_free;
  logic [CHUNK_W:0]       free_cnt;
  logic [CHUNK_W-1:0]     free_lo;
  logic                   chunk_any;
  logic [BLK_W-1:0]       alloc_blk;
  logic [ENT_W-1:0]       free_ent;
  logic                   ram_we;
  logic                   ram_re;
  logic [ENT_W+POS_W-1:0] ram_waddr;
  logic [ENT_W+POS_W-1:0] ram_raddr;
  logic [BLK_W-1:0]       ram_rdata;

  always_comb begin
    logic [BLK_W-1:0] bidx;
    chunk_free = '0;
    free_cnt   = '0;
    free_lo    = '0;
    for (int k = 0; k < CHUNK; k++) begin
      bidx          = {chunk_r, CHUNK_W'(k)};
      chunk_free[k] = !(AVAIL_W'(bidx) < reserved_r) && !map_r[bidx];
    end
    for (int k = 0; k < CHUNK; k++) begin
      free_cnt = free_cnt + (CHUNK_W + 1)'(chunk_free[k]);
    end
    for (int k = CHUNK - 1; k >= 0; k--) begin
      if (chunk_free[k]) begin
        free_lo = CHUNK_W'(k);
      end
    end
  end

  assign chunk_any = |chunk_free;
  assign alloc_blk = {chunk_r, free_lo};

  always_comb begin
    free_ent = '0;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (!valid_r[e]) begin
        free_ent = ENT_W'(e);
      end
    end
  end

  assign ram_we    = cmd_i.alloc && chunk_any;
  assign ram_waddr = {slot_r, pos_r[POS_W-1:0]};
  assign ram_re    = cmd_i.lookup_rd || cmd_i.free_rd;
  assign ram_raddr = cmd_i.lookup_rd ? {ent_r, req_r.block_index[POS_W-1:0]}
                                     : {slot_r, pos_r[POS_W-1:0]};

  fba_ram #(
    .WIDTH(BLK_W),
    .DEPTH(PTR_DEPTH)
  ) u_ptr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(alloc_blk),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    stat_o            = '0;
    stat_o.req_type   = req_r.req_type;
    stat_o.too_large  = req_r.block_count > MAX_LEN;
    stat_o.count_last = (chunk_r == CHK_W'(NUM_CHUNKS - 1));
    stat_o.no_space   = avail_r < AVAIL_W'(req_r.block_count);
    stat_o.table_full = &valid_r;
    stat_o.alloc_done = (pos_r == req_r.block_count);
    stat_o.match      = valid_r[ent_r] && (name_r[ent_r] == req_r.file_name);
    stat_o.scan_last  = (ent_r == ENT_W'(NUM_ENTRIES - 1));
    stat_o.range_bad  = (req_r.block_index >= len_r[ent_r]) ||
                        (req_r.block_index >= MAX_LEN);
    stat_o.free_more  = pos_r < flen_r;
    stat_o.free_pend  = free_pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r   <= CFG_W'(1);
      map_r        <= '0;
      valid_r      <= '0;
      free_pend_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        reserved_r <= cfg_data;
      end
      if (ram_we) begin
        map_r[alloc_blk] <= 1'b1;
      end
      if (free_pend_r) begin
        map_r[ram_rdata] <= 1'b0;
      end
      if (cmd_i.commit) begin
        valid_r[slot_r] <= 1'b1;
      end
      if (cmd_i.invalidate) begin
        valid_r[slot_r] <= 1'b0;
      end
      free_pend_r  <= cmd_i.free_rd;
      out_strobe_r <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_r   <= in_req;
      chunk_r <= '0;
      avail_r <= '0;
      ent_r   <= '0;
      pos_r   <= '0;
    end
    if (cmd_i.count) begin
      avail_r <= avail_r + AVAIL_W'(free_cnt);
      chunk_r <= chunk_r + CHK_W'(1);
    end
    if (cmd_i.take_slot) begin
      slot_r  <= free_ent;
      chunk_r <= '0;
    end
    if (cmd_i.alloc) begin
      if (chunk_any) begin
        pos_r <= pos_r + CNT_W'(1);
      end else begin
        chunk_r <= chunk_r + CHK_W'(1);
      end
    end
    if (cmd_i.search) begin
      if (stat_o.match) begin
        slot_r <= ent_r;
        flen_r <= len_r[ent_r];
      end
      ent_r <= ent_r + ENT_W'(1);
    end
    if (cmd_i.free_rd) begin
      pos_r <= pos_r + CNT_W'(1);
    end
    if (cmd_i.commit) begin
      name_r[slot_r] <= req_r.file_name;
      len_r[slot_r]  <= req_r.block_count;
    end
    if (cmd_i.respond) begin
      out_rsp_r.status       <= cmd_i.status;
      out_rsp_r.block_number <= cmd_i.use_blk ? ram_rdata : '0;
      unique case (cmd_i.slot_sel)
        SLOT_HELD: out_rsp_r.entry_slot <= slot_r;
        SLOT_SCAN: out_rsp_r.entry_slot <= ent_r;
        default:   out_rsp_r.entry_slot <= '0;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

`ifndef SYNTH
  a_alloc_free_block: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !map_r[alloc_blk] && !(AVAIL_W'(alloc_blk) < reserved_r))
    else $error("allocated a block that is in use");

  a_free_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    free_pend_r |-> !ram_we)
    else $error("block free overlaps an allocation");

  a_commit_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |-> pos_r == req_r.block_count && !valid_r[slot_r])
    else $error("entry committed with missing blocks or over a live entry");
`endif

endmodule

@@ rtl/core/file_block_allocator_table.sv @@
// An unknown request or an oversized create is answered from dispatch. A create counts free
// blocks over all 8-block chunks, answers no space or full table, else allocates its blocks,
// skipping chunks with no free block. Lookup and delete search the entries in order; delete
// frees each block of the file; a name not found is answered after the last entry. Busy
// drops with the strobe; the receiver cannot stall. Synchronous reset clears the block map
// and entry valid bits and sets reserved_blocks to 1; there is no clearing pass.
module file_block_allocator_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  fba_pkg::fba_req_t         in_req,
  output logic                      out_strobe,
  output fba_pkg::fba_rsp_t         out_rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fba_pkg::CFG_W-1:0] cfg_data
);
  import fba_pkg::*;

  fba_cmd_t  cmd;
  fba_stat_t stat;
  logic      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  fba_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  fba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp)
  );

endmodule
